// File: hw/rtl/assert_macros.svh
// Assertion helpers for the ROI depth statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/rds_pkg.sv
package rds_pkg;

    localparam int FRAME_DIM_DEFAULT = 256;
    localparam int DW = 16;
    localparam int CW = 17;
    localparam int SUMW = 33;
    localparam int SQW = 49;
    localparam logic [CW-1:0] VALID_CAP = 17'd65536;
    localparam logic [CW-1:0] CAND_CAP = 17'd131071;
    localparam logic [DW-1:0] STD_FLOOR = 16'd10;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_VALID = 2'd1;
    localparam logic [1:0] ST_LOW_CONF = 2'd2;

    localparam logic [2:0] REG_FIRST_X = 3'd0;
    localparam logic [2:0] REG_LAST_X = 3'd1;
    localparam logic [2:0] REG_FIRST_Y = 3'd2;
    localparam logic [2:0] REG_LAST_Y = 3'd3;
    localparam logic [2:0] REG_MIN_DEPTH = 3'd4;
    localparam logic [2:0] REG_MAX_DEPTH = 3'd5;
    localparam logic [2:0] REG_SD_LIMIT = 3'd6;
    localparam logic [2:0] REG_MIN_CONF = 3'd7;

    typedef enum logic [3:0] {
        S_ACC,
        S_MUL1,
        S_MUL2,
        S_DIV1,
        S_SQRT,
        S_MUL3,
        S_DIV2,
        S_DIV3,
        S_DONE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic start_mul1;
        logic start_mul2;
        logic start_div1;
        logic start_sqrt;
        logic start_mul3;
        logic start_div2;
        logic start_div3;
        logic finish;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic no_valid;
    } stat_t;

endpackage

// File: hw/rtl/rds_divider.sv
module rds_divider #(
    parameter int NW = 64,
    parameter int DVW = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    output logic           done,
    output logic [NW-1:0]  quot
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DVW:0] r_reg, r_next;
    logic [DVW-1:0] d_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DVW:0] trial;
    logic go;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[DVW-1:0], q_reg[NW-1]};
        go = start && !busy_reg;
        if (go) begin
            q_next = num;
            r_next = '0;
            cnt_next = CNTW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (go) begin
            d_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// File: hw/rtl/rds_sqrt.sv
module rds_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [63:0] trial;
    logic go;

    always_comb begin
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = res_reg + bit_reg;
        go = start && !busy_reg;
        if (go) begin
            v_next = val;
            res_next = '0;
            bit_next = 64'd1 << 62;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

// File: hw/rtl/rds_datapath.sv
module rds_datapath #(
    parameter int FRAME_DIM = rds_pkg::FRAME_DIM_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rds_pkg::cmd_t cmd,
    output rds_pkg::stat_t stat,
    input  logic [15:0]   depth_sample,
    input  logic          sample_finite,
    input  logic [7:0]    pixel_x,
    input  logic [7:0]    pixel_y,
    input  logic [7:0]    roi_first_x,
    input  logic [7:0]    roi_last_x,
    input  logic [7:0]    roi_first_y,
    input  logic [7:0]    roi_last_y,
    input  logic [15:0]   min_valid_depth,
    input  logic [15:0]   max_valid_depth,
    input  logic [15:0]   stddev_limit,
    input  logic [15:0]   min_confidence,
    output logic [82:0]   result
);
    import rds_pkg::*;

    localparam int PW = (FRAME_DIM > 256) ? 13 : 9;

    logic [SUMW-1:0] sum_reg;
    logic [SQW-1:0] sq_reg;
    logic [DW-1:0] min_reg, max_reg;
    logic [CW-1:0] vcnt_reg, ccnt_reg;

    logic [63:0] a_reg, b_reg;
    logic [31:0] sd_reg;
    logic [DW-1:0] lim_reg;
    logic [82:0] res_reg;

    logic [7:0] lox, hix, loy, hiy;
    logic [PW-1:0] dim_max;
    logic cand, valid;
    logic [15:0] hi_lim;

    logic div_start, div_done, sq_done;
    logic [63:0] div_num, div_den, div_q;
    logic [31:0] sq_root;

    function automatic logic [7:0] clampd(input logic [7:0] v, input logic [PW-1:0] m);
        clampd = ({{(PW-8){1'b0}}, v} > m) ? m[7:0] : v;
    endfunction

    always_comb begin
        dim_max = PW'(FRAME_DIM - 1);
        lox = clampd((roi_first_x < roi_last_x) ? roi_first_x : roi_last_x, dim_max);
        hix = clampd((roi_first_x < roi_last_x) ? roi_last_x : roi_first_x, dim_max);
        loy = clampd((roi_first_y < roi_last_y) ? roi_first_y : roi_last_y, dim_max);
        hiy = clampd((roi_first_y < roi_last_y) ? roi_last_y : roi_first_y, dim_max);
        cand = ({{(PW-8){1'b0}}, pixel_x} <= dim_max) && ({{(PW-8){1'b0}}, pixel_y} <= dim_max)
            && pixel_x >= lox && pixel_x <= hix && pixel_y >= loy && pixel_y <= hiy;
        hi_lim = (max_valid_depth < min_valid_depth) ? min_valid_depth : max_valid_depth;
        valid = cand && sample_finite && depth_sample >= min_valid_depth
            && depth_sample <= hi_lim && vcnt_reg < VALID_CAP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            sum_reg <= '0;
            sq_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
            vcnt_reg <= '0;
            ccnt_reg <= '0;
        end else if (cmd.acc_en && cand) begin
            if (ccnt_reg < CAND_CAP) begin
                ccnt_reg <= ccnt_reg + 1'b1;
            end
            if (valid) begin
                sum_reg <= sum_reg + SUMW'(depth_sample);
                sq_reg <= sq_reg + SQW'({16'd0, depth_sample} * {16'd0, depth_sample});
                if (depth_sample < min_reg) min_reg <= depth_sample;
                if (depth_sample > max_reg) max_reg <= depth_sample;
                vcnt_reg <= vcnt_reg + 1'b1;
            end
        end
    end

    // a holds n times the low half of sqsum, b holds sum^2; then num and n^2, later the confidence operands.
    always_ff @(posedge aclk) begin
        if (cmd.start_mul1) begin
            a_reg <= 64'(vcnt_reg) * 64'(sq_reg[31:0]);
            b_reg <= 64'(sum_reg) * 64'(sum_reg);
            lim_reg <= (stddev_limit < STD_FLOOR) ? STD_FLOOR : stddev_limit;
        end
        if (cmd.start_mul2) begin
            a_reg <= a_reg + ((64'(vcnt_reg) * 64'(sq_reg[SQW-1:32])) << 32) - b_reg;
            b_reg <= 64'(vcnt_reg) * 64'(vcnt_reg);
        end
        if (sq_done && !cmd.start_mul3) begin
            sd_reg <= sq_root;
        end
        if (cmd.start_mul3) begin
            a_reg <= 64'(vcnt_reg) * 64'(lim_reg - ((sd_reg < 32'(lim_reg)) ?
                sd_reg[15:0] : lim_reg)) << 16;
            b_reg <= 64'(ccnt_reg) * 64'(lim_reg);
        end
        if (cmd.start_div2 && div_done) begin
            b_reg <= (div_q > 64'd65535) ? 64'd65535 : div_q;
        end
    end

    always_comb begin
        div_start = cmd.start_div1 || cmd.start_div2 || cmd.start_div3;
        div_num = a_reg;
        div_den = b_reg;
        if (cmd.start_div3) begin
            div_num = 64'(sum_reg) + 64'(vcnt_reg[CW-1:1]);
            div_den = 64'(vcnt_reg);
        end
    end

    rds_divider #(.NW(64), .DVW(64)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start && !div_done),
        .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
    );

    rds_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start_sqrt && !sq_done),
        .val(div_q), .done(sq_done), .root(sq_root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (vcnt_reg == '0) begin
                res_reg <= {16'd0, 17'd0, 16'd0, 16'd0, 16'd0, ST_NO_VALID};
            end else begin
                res_reg <= {b_reg[15:0], vcnt_reg, max_reg, min_reg, div_q[15:0],
                    (min_confidence != 16'd0 && b_reg[15:0] < min_confidence) ?
                    ST_LOW_CONF : ST_OK};
            end
        end
    end

    assign result = res_reg;
    assign stat.unit_done = div_done || sq_done;
    assign stat.no_valid = (vcnt_reg == '0);
endmodule

// File: hw/rtl/rds_ctrl.sv
module rds_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          in_last,
    input  logic          out_ready,
    input  rds_pkg::stat_t stat,
    output rds_pkg::cmd_t cmd,
    output logic          in_ready,
    output logic          out_valid
);
    import rds_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_ACC: if (in_fire && in_last) state_next = S_MUL1;
            S_MUL1: state_next = stat.no_valid ? S_DONE : S_MUL2;
            S_MUL2: state_next = S_DIV1;
            S_DIV1: if (stat.unit_done) state_next = S_SQRT;
            S_SQRT: if (stat.unit_done) state_next = S_MUL3;
            S_MUL3: state_next = S_DIV2;
            S_DIV2: if (stat.unit_done) state_next = S_DIV3;
            S_DIV3: if (stat.unit_done) state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT: if (out_ready) state_next = S_ACC;
            default: state_next = S_ACC;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_ACC: begin
                in_ready = 1'b1;
                cmd.acc_en = in_fire;
            end
            S_MUL1: cmd.start_mul1 = 1'b1;
            S_MUL2: cmd.start_mul2 = 1'b1;
            S_DIV1: cmd.start_div1 = 1'b1;
            S_SQRT: cmd.start_sqrt = 1'b1;
            S_MUL3: cmd.start_mul3 = 1'b1;
            S_DIV2: cmd.start_div2 = 1'b1;
            S_DIV3: cmd.start_div3 = 1'b1;
            S_DONE: cmd.finish = 1'b1;
            S_OUT: begin
                out_valid = 1'b1;
                cmd.clear = out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_ACC;
        else state_reg <= state_next;
    end
endmodule

// File: hw/rtl/roi_depth_statistics_top.sv
// Accepts one pixel per cycle while accumulating a frame.
// After the frame-end item is accepted, the result item is computed with three 64-step
// divisions and a 32-step square root. A frame with no valid pixel skips these and
// goes from state S_MUL1 straight to S_DONE and S_OUT.
// Input is held off from the frame end until the result item is taken.
// Synchronous active-low reset restores register defaults and clears the frame.
module roi_depth_statistics_top #(
    parameter int FRAME_DIM = rds_pkg::FRAME_DIM_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // depth_sample, sample_finite, pixel_x, pixel_y, zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // status, mean_depth, min_depth, max_depth, valid_count,
                                  // confidence, zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rds_pkg::*;

    logic [7:0] fx_reg, lx_reg, fy_reg, ly_reg;
    logic [15:0] mind_reg, maxd_reg, sdl_reg, minc_reg;
    cmd_t cmd;
    stat_t stat;
    logic [82:0] result;
    logic in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fx_reg <= 8'd0;
            lx_reg <= 8'd255;
            fy_reg <= 8'd0;
            ly_reg <= 8'd255;
            mind_reg <= 16'd0;
            maxd_reg <= 16'd65535;
            sdl_reg <= 16'd500;
            minc_reg <= 16'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FIRST_X: fx_reg <= cfg_data[7:0];
                REG_LAST_X: lx_reg <= cfg_data[7:0];
                REG_FIRST_Y: fy_reg <= cfg_data[7:0];
                REG_LAST_Y: ly_reg <= cfg_data[7:0];
                REG_MIN_DEPTH: mind_reg <= cfg_data;
                REG_MAX_DEPTH: maxd_reg <= cfg_data;
                REG_SD_LIMIT: sdl_reg <= cfg_data;
                REG_MIN_CONF: minc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;

    rds_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_tlast),
        .out_ready(m_tready), .stat(stat), .cmd(cmd), .in_ready(s_tready),
        .out_valid(m_tvalid)
    );

    rds_datapath #(.FRAME_DIM(FRAME_DIM)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .depth_sample(s_tdata[15:0]), .sample_finite(s_tdata[16]),
        .pixel_x(s_tdata[24:17]), .pixel_y(s_tdata[32:25]),
        .roi_first_x(fx_reg), .roi_last_x(lx_reg), .roi_first_y(fy_reg),
        .roi_last_y(ly_reg), .min_valid_depth(mind_reg), .max_valid_depth(maxd_reg),
        .stddev_limit(sdl_reg), .min_confidence(minc_reg), .result(result)
    );

    assign m_tdata = {5'd0, result};

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_status, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rds_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] mean;
        logic [15:0] min_d;
        logic [15:0] max_d;
        logic [16:0] count;
        logic [15:0] conf;
    } frame_stats_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    roi_depth_statistics_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    frame_stats_t pending_stats[$];
    int unsigned  error_count = 0;
    longint unsigned cycle_count = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    int unsigned  rx_hold = 0;
    int unsigned  rx_stall = 0;

    // Shadow registers and frame accumulators of the block.
    logic [15:0]     shadow_reg[8];
    longint unsigned acc_sum, acc_sq;
    logic [15:0]     acc_min, acc_max;
    logic [16:0]     acc_valid, acc_cand;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch in %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        frame_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("unexpected result item", 1, 0);
            end else begin
                want = pending_stats.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", m_tdata[1:0], want.status);
                if (m_tdata[17:2] !== want.mean)
                    report_mismatch("mean_depth", m_tdata[17:2], want.mean);
                if (m_tdata[33:18] !== want.min_d)
                    report_mismatch("min_depth", m_tdata[33:18], want.min_d);
                if (m_tdata[49:34] !== want.max_d)
                    report_mismatch("max_depth", m_tdata[49:34], want.max_d);
                if (m_tdata[66:50] !== want.count)
                    report_mismatch("valid_count", m_tdata[66:50], want.count);
                if (m_tdata[82:67] !== want.conf)
                    report_mismatch("confidence", m_tdata[82:67], want.conf);
            end
        end
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void clear_frame_acc();
        acc_sum = 0;
        acc_sq = 0;
        acc_min = 16'hFFFF;
        acc_max = 0;
        acc_valid = 0;
        acc_cand = 0;
    endfunction

    function automatic bit within_bounds(logic [7:0] p, logic [7:0] a, logic [7:0] b);
        return (a < b) ? (p >= a && p <= b) : (p >= b && p <= a);
    endfunction

    // Accumulates one pixel and, on frame end, queues the statistics it yields.
    function automatic void predict_pixel(logic [15:0] d, bit fin, logic [7:0] x,
                                          logic [7:0] y, bit fend);
        frame_stats_t r;
        logic [15:0] top;
        longint unsigned n, lim, sd, stab, c;
        if (within_bounds(x, shadow_reg[REG_FIRST_X][7:0], shadow_reg[REG_LAST_X][7:0]) &&
            within_bounds(y, shadow_reg[REG_FIRST_Y][7:0], shadow_reg[REG_LAST_Y][7:0])) begin
            top = (shadow_reg[REG_MAX_DEPTH] < shadow_reg[REG_MIN_DEPTH]) ?
                  shadow_reg[REG_MIN_DEPTH] : shadow_reg[REG_MAX_DEPTH];
            if (acc_cand < CAND_CAP) acc_cand++;
            if (fin && d >= shadow_reg[REG_MIN_DEPTH] && d <= top && acc_valid < VALID_CAP) begin
                acc_sum += d;
                acc_sq += longint'(d) * d;
                if (d < acc_min) acc_min = d;
                if (d > acc_max) acc_max = d;
                acc_valid++;
            end
        end
        if (!fend) return;
        r = '{ST_NO_VALID, 0, 0, 0, 0, 0};
        if (acc_valid != 0) begin
            n = acc_valid;
            lim = (shadow_reg[REG_SD_LIMIT] < STD_FLOOR) ? STD_FLOOR : shadow_reg[REG_SD_LIMIT];
            sd = floor_root((n * acc_sq - acc_sum * acc_sum) / (n * n));
            stab = lim - ((sd < lim) ? sd : lim);
            c = ((n * stab) << 16) / (longint'(acc_cand) * lim);
            r.mean = 16'((acc_sum + n / 2) / n);
            r.min_d = acc_min;
            r.max_d = acc_max;
            r.count = n[16:0];
            r.conf = (c > 65535) ? 16'hFFFF : c[15:0];
            r.status = (shadow_reg[REG_MIN_CONF] != 0 && r.conf < shadow_reg[REG_MIN_CONF]) ?
                       ST_LOW_CONF : ST_OK;
        end
        pending_stats.push_back(r);
        clear_frame_acc();
    endfunction

    task automatic send_pixel(logic [15:0] d, bit fin, logic [7:0] x, logic [7:0] y, bit fend);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, y, x, fin, d};
        s_tlast <= fend;
        do @(posedge aclk); while (!s_tready);
        predict_pixel(d, fin, x, y, fend);
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_reg[idx] = (idx <= REG_LAST_Y) ? {8'b0, val[7:0]} : val;
    endtask

    task automatic write_defaults();
        write_reg(REG_FIRST_X, 0);
        write_reg(REG_LAST_X, 255);
        write_reg(REG_FIRST_Y, 0);
        write_reg(REG_LAST_Y, 255);
        write_reg(REG_MIN_DEPTH, 0);
        write_reg(REG_MAX_DEPTH, 16'hFFFF);
        write_reg(REG_SD_LIMIT, 500);
        write_reg(REG_MIN_CONF, 0);
    endtask

    task automatic write_random_config();
        write_reg(REG_FIRST_X, 16'($urandom_range(0, 255)));
        write_reg(REG_LAST_X, 16'($urandom_range(0, 255)));
        write_reg(REG_FIRST_Y, 16'($urandom_range(0, 255)));
        write_reg(REG_LAST_Y, 16'($urandom_range(0, 255)));
        write_reg(REG_MIN_DEPTH, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 2000)));
        write_reg(REG_MAX_DEPTH, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  16'($urandom_range(20000, 65535)));
        write_reg(REG_SD_LIMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 3000)));
        write_reg(REG_MIN_CONF, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom));
    endtask

    function automatic logic [7:0] pick_coord(logic [7:0] a, logic [7:0] b);
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return (a < b) ? 8'($urandom_range(a, b)) : 8'($urandom_range(b, a));
    endfunction

    function automatic logic [15:0] pick_depth();
        logic [15:0] lo = shadow_reg[REG_MIN_DEPTH];
        logic [15:0] hi = shadow_reg[REG_MAX_DEPTH];
        if ($urandom_range(0, 7) == 0 || hi < lo) return 16'($urandom);
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic send_random_frames(int unsigned n_items, int unsigned max_len);
        int unsigned sent = 0;
        int unsigned len;
        while (sent < n_items) begin
            len = $urandom_range(1, max_len);
            for (int unsigned i = 0; i < len; i++)
                send_pixel(pick_depth(), $urandom_range(0, 9) != 0,
                           pick_coord(shadow_reg[REG_FIRST_X][7:0], shadow_reg[REG_LAST_X][7:0]),
                           pick_coord(shadow_reg[REG_FIRST_Y][7:0], shadow_reg[REG_LAST_Y][7:0]),
                           i == len - 1);
            sent += len;
        end
        end_stream();
    endtask

    task automatic test_directed_defaults();
        send_pixel(16'hFFFF, 1, 8'hFF, 8'hFF, 1);
        send_pixel(0, 1, 0, 0, 1);
        send_pixel(1234, 0, 5, 5, 0);
        send_pixel(4321, 0, 6, 5, 1);
        send_pixel(1000, 1, 1, 1, 0);
        send_pixel(3000, 1, 2, 1, 0);
        send_pixel(16'hFFFF, 1, 3, 1, 0);
        send_pixel(0, 1, 4, 1, 1);
        end_stream();
        wait_idle();
    endtask

    task automatic test_swapped_roi_and_window();
        write_reg(REG_FIRST_X, 200);
        write_reg(REG_LAST_X, 10);
        write_reg(REG_FIRST_Y, 255);
        write_reg(REG_LAST_Y, 255);
        write_reg(REG_MIN_DEPTH, 5000);
        write_reg(REG_MAX_DEPTH, 100);
        send_pixel(5000, 1, 10, 255, 0);
        send_pixel(5001, 1, 200, 255, 0);
        send_pixel(5000, 1, 9, 255, 0);
        send_pixel(5000, 1, 201, 255, 0);
        send_pixel(5000, 1, 50, 254, 1);
        end_stream();
        wait_idle();
    endtask

    task automatic test_confidence_limits();
        write_defaults();
        write_reg(REG_SD_LIMIT, 0);
        write_reg(REG_MIN_CONF, 16'hFFFF);
        send_pixel(100, 1, 0, 0, 0);
        send_pixel(9000, 1, 1, 0, 0);
        send_pixel(200, 0, 2, 0, 1);
        send_pixel(700, 1, 0, 0, 1);
        end_stream();
        wait_idle();
        write_reg(REG_SD_LIMIT, 16'hFFFF);
        write_reg(REG_MIN_CONF, 1);
        send_pixel(0, 1, 0, 0, 0);
        send_pixel(16'hFFFF, 1, 1, 0, 1);
        end_stream();
        wait_idle();
    endtask

    task automatic test_random_frames();
        for (int p = 0; p < 8; p++) begin
            if (p == 6) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            write_random_config();
            send_random_frames(60, 30);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        write_defaults();
        @(negedge aclk);
        rx_hold = 800;
        @(posedge aclk);
        send_random_frames(40, 6);
        wait_idle();
    endtask

    initial begin
        foreach (shadow_reg[i]) shadow_reg[i] = 0;
        shadow_reg[REG_LAST_X] = 255;
        shadow_reg[REG_LAST_Y] = 255;
        shadow_reg[REG_MAX_DEPTH] = 16'hFFFF;
        shadow_reg[REG_SD_LIMIT] = 500;
        clear_frame_acc();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_defaults();
        test_swapped_roi_and_window();
        test_confidence_limits();
        test_backpressure();
        test_random_frames();
        repeat (250) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rds_pkg.sv
hw/rtl/rds_divider.sv
hw/rtl/rds_sqrt.sv
hw/rtl/rds_datapath.sv
hw/rtl/rds_ctrl.sv
hw/rtl/roi_depth_statistics_top.sv
test/tb_top.sv
